// ----- rtl/srs_pkg.sv -----
// shared types, codes and constants of the service restart supervisor
package srs_pkg;

  // sizing
  localparam int NUM_SLOTS_DEF = 8;
  localparam int MASK_W        = 8;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;
  localparam int S_TDATA_W     = 56;
  localparam int M_TDATA_W     = 48;
  localparam int TUSER_W       = 2;

  // field widths
  localparam int PID_W   = 16;
  localparam int TICK_W  = 32;
  localparam int OSLOT_W = 3;
  localparam int CNT_W   = 8;
  localparam int BOFF_W  = 16;
  localparam int FAST_W  = 16;
  localparam int LIFE_W  = 20;

  // register reset values
  localparam logic [BOFF_W-1:0] BACKOFF_RST  = BOFF_W'(100);
  localparam logic [FAST_W-1:0] FAST_RST     = FAST_W'(100);
  localparam logic [LIFE_W-1:0] RESET_LIFE_RST = LIFE_W'(6000);
  localparam logic [CNT_W-1:0]  MAX_FAST_RST = CNT_W'(5);
  localparam logic [CNT_W-1:0]  CNT_SAT      = '1;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_SPAWN = 2'd1,
    REQ_EXIT  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_LAUNCH  = 2'd0,
    KIND_EXITED  = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_GAVE_UP = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_BACKOFF    = 3'd0,
    REG_FAST_DEATH = 3'd1,
    REG_RESET_LIFE = 3'd2,
    REG_MAX_FAST   = 3'd3,
    REG_PRESENT    = 3'd4,
    REG_RESPAWN    = 3'd5,
    REG_GFX_ONLY   = 3'd6,
    REG_GUI_MODE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [BOFF_W-1:0] restart_delay;
    logic [FAST_W-1:0] quick_limit;
    logic [LIFE_W-1:0] stable_limit;
    logic [CNT_W-1:0]  quick_cap;
    logic [MASK_W-1:0] present_mask;
    logic [MASK_W-1:0] respawn_mask;
    logic [MASK_W-1:0] gfx_only_mask;
    logic              gui_mode;
  } cfg_t;

  // one result item
  typedef struct packed {
    kind_t              kind;
    logic [OSLOT_W-1:0] out_slot;
    logic [TICK_W-1:0]  life_ticks;
    logic [CNT_W-1:0]   death_count;
  } res_t;

  // sequencer to result queue
  typedef struct packed {
    logic push;
    logic flush;
  } rq_ctl_t;

  // result queue to sequencer
  typedef struct packed {
    logic can_push;
    logic flush_ok;
  } rq_sts_t;

  // per-slot record kept in memory
  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [PID_W-1:0]  owner_id;
    logic [TICK_W-1:0] started_at;
    logic [CNT_W-1:0]  quick_exits;
    logic              running;
    logic              gave_up;
    logic              restart_pending;
  } ent_t;

endpackage

// ----- rtl/service_restart_supervisor_unit.sv -----
// service restart supervisor: slot scan sequencer over a per-slot record memory
// Sequence: an item is taken in the idle state; each eligible slot then takes a read
//   state (memory read) and a modify state (modify and write back, waiting for room in
//   the result queue), a skipped slot only a read state, and a closing state waits for the flush.
// Throughput: one item at a time, bounded by the single read-modify-write slot port.
// Reset: synchronous; registers return to their defaults and the per-slot valid
//   bits clear at once, so never-written records read as zero. No clearing pass.
module service_restart_supervisor_unit #(
  parameter int NUM_SLOTS = srs_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [srs_pkg::S_TDATA_W-1:0] s_tdata,   // slot, proc_id, spawn_ok, now_tick
  input  logic [srs_pkg::TUSER_W-1:0]   s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [srs_pkg::M_TDATA_W-1:0] m_tdata,   // out_slot, life_ticks, death_count
  output logic [srs_pkg::TUSER_W-1:0]   m_tuser,   // kind
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srs_pkg::CFG_AW-1:0]    paddr,
  input  logic [srs_pkg::CFG_DW-1:0]    pwdata,
  output logic [srs_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import srs_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCAN   = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;
  localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(SCAN - 1);
  localparam int ENT_W  = $bits(ent_t);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EX   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  idx_next;
  logic [OSLOT_W-1:0] idx3;

  // captured item
  req_t               it_type;
  logic [OSLOT_W-1:0] it_slot;
  logic [PID_W-1:0]   it_pid;
  logic               it_ok;
  logic [TICK_W-1:0]  it_now;

  cfg_t    cfg;
  rq_ctl_t rq_ctl;
  rq_sts_t rq_sts;
  res_t    res;
  logic    hold_valid;

  // memory side
  logic             valid [NUM_SLOTS];
  logic             rd_vld;
  logic             ram_re;
  logic             ram_we;
  logic [ENT_W-1:0] ram_rdata;
  ent_t             ent;
  ent_t             ent_new;

  // per-slot evaluation
  logic              accept;
  logic              spawn_go;
  logic              eligible;
  logic              last_slot;
  logic              proceed;
  logic              emit;
  logic              hit;
  logic              resp;
  logic              give_up;
  logic              fire;
  logic [TICK_W-1:0] life;
  logic [TICK_W-1:0] since_dl;
  logic [CNT_W-1:0]  q_new;

  srs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ent_new),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  srs_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rq_ctl),
    .res_in     (res),
    .sts        (rq_sts),
    .hold_valid (hold_valid),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign idx3      = OSLOT_W'(idx);
  assign last_slot = (idx == SCAN_LAST);

  // a spawn outcome that touches the slot record
  assign spawn_go = (32'(s_tdata[2:0]) < NUM_SLOTS) && s_tdata[19] &&
                    (s_tdata[18:3] != '0);

  // slot eligibility for a scan
  always_comb begin
    eligible = 1'b0;
    case (it_type)
      REQ_SPAWN: eligible = 1'b1;
      REQ_START: eligible = cfg.present_mask[idx3] &&
                            !(cfg.gfx_only_mask[idx3] && !cfg.gui_mode);
      default:   eligible = cfg.present_mask[idx3];
    endcase
  end

  // record as read, zero where never written
  assign ent = rd_vld ? ent_t'(ram_rdata) : '0;

  // exit bookkeeping
  assign hit      = ent.running && (ent.owner_id == it_pid);
  assign life     = it_now - ent.started_at;
  assign resp     = cfg.respawn_mask[idx3] && !ent.gave_up;
  assign since_dl = it_now - ent.deadline;
  assign fire     = ent.restart_pending && !ent.gave_up && !since_dl[TICK_W-1];

  always_comb begin
    if (life > TICK_W'(cfg.stable_limit)) begin
      q_new = '0;
    end else if ((life < TICK_W'(cfg.quick_limit)) && (ent.quick_exits != CNT_SAT)) begin
      q_new = ent.quick_exits + CNT_W'(1);
    end else begin
      q_new = ent.quick_exits;
    end
  end
  assign give_up = resp && (q_new >= cfg.quick_cap);

  // new record and result
  always_comb begin
    ent_new         = ent;
    emit            = 1'b0;
    res.kind        = KIND_LAUNCH;
    res.out_slot    = idx3;
    res.life_ticks  = '0;
    res.death_count = ent.quick_exits;
    case (it_type)
      REQ_SPAWN: begin
        ent_new.running    = 1'b1;
        ent_new.owner_id   = it_pid;
        ent_new.started_at = it_now;
      end
      REQ_START: begin
        ent_new.restart_pending = 1'b0;
        emit = 1'b1;
      end
      REQ_EXIT: begin
        res.life_ticks  = life;
        res.death_count = q_new;
        if (hit) begin
          emit                = 1'b1;
          ent_new.running     = 1'b0;
          ent_new.owner_id    = '0;
          ent_new.quick_exits = q_new;
          if (!resp) begin
            res.kind = KIND_EXITED;
          end else if (give_up) begin
            res.kind        = KIND_GAVE_UP;
            ent_new.gave_up = 1'b1;
          end else begin
            res.kind                = KIND_RESTART;
            ent_new.restart_pending = 1'b1;
            ent_new.deadline        = it_now + TICK_W'(cfg.restart_delay);
          end
        end
      end
      default: begin
        if (fire) begin
          emit                    = 1'b1;
          ent_new.restart_pending = 1'b0;
        end
      end
    endcase
  end

  // a scan step other than a spawn waits for room in the result queue
  assign proceed = (it_type == REQ_SPAWN) || rq_sts.can_push;

  assign ram_re      = (state == ST_RD) && eligible;
  assign ram_we      = (state == ST_EX) && proceed;
  assign rq_ctl.push  = (state == ST_EX) && proceed && emit;
  assign rq_ctl.flush = (state == ST_FIN);

  // sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_t'(s_tuser) != REQ_SPAWN) begin
            state_next = ST_RD;
            idx_next   = '0;
          end else if (spawn_go) begin
            state_next = ST_RD;
            idx_next   = SLOT_W'(s_tdata[2:0]);
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RD: begin
        if (eligible) begin
          state_next = ST_EX;
        end else if (last_slot) begin
          state_next = ST_FIN;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end
      ST_EX: begin
        if (proceed) begin
          if (last_slot || (it_type == REQ_SPAWN)) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_RD;
            idx_next   = idx + SLOT_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (rq_sts.flush_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      it_type <= req_t'(s_tuser);
      it_slot <= s_tdata[2:0];
      it_pid  <= s_tdata[18:3];
      it_ok   <= s_tdata[19];
      it_now  <= s_tdata[51:20];
    end
  end

  // record valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (ram_we) begin
        valid[idx] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld <= valid[idx];
      end
    end
  end

  // checks
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("result left in hold stage while idle");

  a_write_in_ex: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EX))
    else $error("record write outside modify step");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (32'(idx) < NUM_SLOTS))
    else $error("slot read beyond memory depth");

  a_ex_after_read: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EX) && !$past(state == ST_EX)) |-> $past(ram_re))
    else $error("modify step without a read");

  a_spawn_ok: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (it_type == REQ_SPAWN)) |-> (it_ok && (it_pid != '0) &&
                                             (OSLOT_W'(idx) == it_slot)))
    else $error("spawn record written for a rejected outcome");

endmodule

// ----- rtl/srs_ram.sv -----
// generic single-write, single-read ram with registered read
module srs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/srs_cfg.sv -----
// apb configuration registers of the restart supervisor
module srs_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [srs_pkg::CFG_AW-1:0] paddr,
  input  logic [srs_pkg::CFG_DW-1:0] pwdata,
  output logic [srs_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output srs_pkg::cfg_t              cfg
);
  import srs_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.restart_delay <= BACKOFF_RST;
      cfg.quick_limit   <= FAST_RST;
      cfg.stable_limit  <= RESET_LIFE_RST;
      cfg.quick_cap     <= MAX_FAST_RST;
      cfg.present_mask  <= '0;
      cfg.respawn_mask  <= '0;
      cfg.gfx_only_mask <= '0;
      cfg.gui_mode      <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_BACKOFF:    cfg.restart_delay <= pwdata[BOFF_W-1:0];
        REG_FAST_DEATH: cfg.quick_limit   <= pwdata[FAST_W-1:0];
        REG_RESET_LIFE: cfg.stable_limit  <= pwdata[LIFE_W-1:0];
        REG_MAX_FAST:   cfg.quick_cap     <= pwdata[CNT_W-1:0];
        REG_PRESENT:    cfg.present_mask  <= pwdata[MASK_W-1:0];
        REG_RESPAWN:    cfg.respawn_mask  <= pwdata[MASK_W-1:0];
        REG_GFX_ONLY:   cfg.gfx_only_mask <= pwdata[MASK_W-1:0];
        REG_GUI_MODE:   cfg.gui_mode      <= pwdata[0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_BACKOFF:    prdata = CFG_DW'(cfg.restart_delay);
      REG_FAST_DEATH: prdata = CFG_DW'(cfg.quick_limit);
      REG_RESET_LIFE: prdata = CFG_DW'(cfg.stable_limit);
      REG_MAX_FAST:   prdata = CFG_DW'(cfg.quick_cap);
      REG_PRESENT:    prdata = CFG_DW'(cfg.present_mask);
      REG_RESPAWN:    prdata = CFG_DW'(cfg.respawn_mask);
      REG_GFX_ONLY:   prdata = CFG_DW'(cfg.gfx_only_mask);
      REG_GUI_MODE:   prdata = CFG_DW'(cfg.gui_mode);
    endcase
  end

endmodule

// ----- rtl/srs_resq.sv -----
// result hold stage and output register; hold marks last once the scan ends
module srs_resq (
  input  logic                          clk,
  input  logic                          rst,
  input  srs_pkg::rq_ctl_t              ctl,
  input  srs_pkg::res_t                 res_in,
  output srs_pkg::rq_sts_t              sts,
  output logic                          hold_valid,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [srs_pkg::M_TDATA_W-1:0] m_tdata,   // out_slot, life_ticks, death_count
  output logic [srs_pkg::TUSER_W-1:0]   m_tuser,   // kind
  output logic                          m_tlast
);
  import srs_pkg::*;

  res_t hold;
  res_t outr;
  logic out_free;

  assign out_free     = !m_tvalid || m_tready;
  assign sts.can_push = !hold_valid || out_free;
  assign sts.flush_ok = !hold_valid || out_free;

  // hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else if (ctl.push && sts.can_push) begin
      hold       <= res_in;
      hold_valid <= 1'b1;
      if (hold_valid) begin
        outr     <= hold;
        m_tlast  <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end else if (ctl.flush && hold_valid && out_free) begin
      outr       <= hold;
      m_tlast    <= 1'b1;
      m_tvalid   <= 1'b1;
      hold_valid <= 1'b0;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = outr.kind;
  assign m_tdata = M_TDATA_W'({outr.death_count, outr.life_ticks, outr.out_slot});

endmodule

// ----- sim/service_restart_supervisor_unit_tb.sv -----
// self-checking testbench for the service restart supervisor unit
module service_restart_supervisor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  // one request item on the slave stream
  typedef struct {
    req_t        req_type;
    logic [2:0]  slot;
    logic [15:0] proc_id;
    logic        spawn_ok;
    logic [31:0] now_tick;
  } sup_req_t;

  // one slot event on the master stream
  typedef struct {
    kind_t       kind;
    logic [2:0]  slot;
    logic [31:0] life;
    logic [7:0]  deaths;
    logic        last;
  } slot_event_t;

  logic clk;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata  = '0;   // slot, proc_id, spawn_ok, now_tick
  logic [TUSER_W-1:0]     s_tuser  = '0;   // req_type
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;         // out_slot, life_ticks, death_count
  logic [TUSER_W-1:0]     m_tuser;         // kind
  logic                   m_tlast;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [CFG_AW-1:0]      paddr    = '0;
  logic [CFG_DW-1:0]      pwdata   = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  service_restart_supervisor_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // requests waiting for the driver and slot events waiting for the monitor
  sup_req_t    request_queue[$];
  slot_event_t awaited_events[$];
  int          fail_count = 0;

  // shadow of the supervisor registers and per-slot records
  cfg_t        cfg_shadow;
  logic [7:0]  slot_running = '0;
  logic [7:0]  slot_gave_up = '0;
  logic [7:0]  slot_pending = '0;
  logic [31:0] slot_deadline [8];
  logic [15:0] slot_owner    [8];
  logic [31:0] slot_started  [8];
  logic [7:0]  slot_quick    [8];

  // stimulus generator bookkeeping
  logic [15:0] gen_pid   [8];
  logic [31:0] gen_start [8];
  logic [31:0] gen_now = '0;

  // driver and monitor controls
  bit          idle_on      = 1'b1;
  bit          hold_trigger = 1'b0;
  bit          hold_taken   = 1'b0;
  bit          offering;
  sup_req_t    live_req;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // expected slot events for one accepted request
  task automatic predict_slot_events(sup_req_t rq);
    slot_event_t batch [8];
    int          n;
    int          i;
    logic [31:0] life;
    logic [31:0] since;
    kind_t       k;
    n = 0;
    if (rq.req_type == REQ_SPAWN) begin
      // zero id counts as a failed spawn
      if (rq.spawn_ok && rq.proc_id != '0) begin
        slot_running[rq.slot] = 1'b1;
        slot_owner[rq.slot]   = rq.proc_id;
        slot_started[rq.slot] = rq.now_tick;
      end
      return;
    end
    for (i = 0; i < 8; i++) begin
      if (cfg_shadow.present_mask[i]) begin
        case (rq.req_type)
          REQ_START: begin
            if (!cfg_shadow.gfx_only_mask[i] || cfg_shadow.gui_mode) begin
              slot_pending[i] = 1'b0;
              batch[n] = '{KIND_LAUNCH, 3'(i), 32'd0, slot_quick[i], 1'b0};
              n++;
            end
          end
          REQ_EXIT: begin
            if (slot_running[i] && slot_owner[i] == rq.proc_id) begin
              slot_running[i] = 1'b0;
              slot_owner[i]   = '0;
              life = rq.now_tick - slot_started[i];
              // long life clears the count, short life bumps it up to saturation
              if (life > 32'(cfg_shadow.stable_limit))
                slot_quick[i] = '0;
              else if (life < 32'(cfg_shadow.quick_limit) && slot_quick[i] != CNT_SAT)
                slot_quick[i] = slot_quick[i] + 8'd1;
              k = KIND_EXITED;
              if (cfg_shadow.respawn_mask[i] && !slot_gave_up[i]) begin
                if (slot_quick[i] >= cfg_shadow.quick_cap) begin
                  slot_gave_up[i] = 1'b1;
                  k = KIND_GAVE_UP;
                end else begin
                  slot_pending[i]  = 1'b1;
                  slot_deadline[i] = rq.now_tick + 32'(cfg_shadow.restart_delay);
                  k = KIND_RESTART;
                end
              end
              batch[n] = '{k, 3'(i), life, slot_quick[i], 1'b0};
              n++;
            end
          end
          default: begin
            // deadline passed when the wrapped difference is non-negative
            since = rq.now_tick - slot_deadline[i];
            if (slot_pending[i] && !slot_gave_up[i] && !since[31]) begin
              slot_pending[i] = 1'b0;
              batch[n] = '{KIND_LAUNCH, 3'(i), 32'd0, slot_quick[i], 1'b0};
              n++;
            end
          end
        endcase
      end
    end
    for (i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      awaited_events.push_back(batch[i]);
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // compare one accepted slot event with the oldest expectation
  task automatic check_slot_event();
    slot_event_t want;
    if (awaited_events.size() == 0) begin
      $display("%0t ns: unexpected event, expected none actual kind %0d slot %0d life %0h",
               $time, m_tuser, m_tdata[2:0], m_tdata[34:3]);
      fail_count++;
      return;
    end
    want = awaited_events.pop_front();
    compare_field("kind", 32'(want.kind), 32'(m_tuser));
    compare_field("out_slot", 32'(want.slot), 32'(m_tdata[2:0]));
    compare_field("life_ticks", want.life, m_tdata[34:3]);
    compare_field("death_count", 32'(want.deaths), 32'(m_tdata[42:35]));
    compare_field("last", 32'(want.last), 32'(m_tlast));
  endtask

  // request driver with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      offering = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) predict_slot_events(live_req);
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (request_queue.size() != 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(0, 5);
          end else begin
            live_req = request_queue.pop_front();
            s_tdata  <= {4'b0, live_req.now_tick, live_req.spawn_ok, live_req.proc_id,
                         live_req.slot};
            s_tuser  <= live_req.req_type;
            offering = 1'b1;
          end
        end
      end
      s_tvalid <= offering;
    end
  end

  // event monitor with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (m_tvalid && m_tready) check_slot_event();
      if (hold_trigger && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= 300;
        m_tready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 5);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void add_req(req_t t, logic [2:0] s, logic [15:0] pid, logic ok,
                                  logic [31:0] now);
    request_queue.push_back('{t, s, pid, ok, now});
  endfunction

  // register write over the config port, shadow updated alongside
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    case (idx)
      REG_BACKOFF:    cfg_shadow.restart_delay = value[15:0];
      REG_FAST_DEATH: cfg_shadow.quick_limit   = value[15:0];
      REG_RESET_LIFE: cfg_shadow.stable_limit  = value[19:0];
      REG_MAX_FAST:   cfg_shadow.quick_cap     = value[7:0];
      REG_PRESENT:    cfg_shadow.present_mask  = value[7:0];
      REG_RESPAWN:    cfg_shadow.respawn_mask  = value[7:0];
      REG_GFX_ONLY:   cfg_shadow.gfx_only_mask = value[7:0];
      default:        cfg_shadow.gui_mode      = value[0];
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] backoff, logic [31:0] fast, logic [31:0] rlife,
                            logic [31:0] maxf, logic [31:0] present, logic [31:0] respawn,
                            logic [31:0] gfx_only, logic [31:0] gui);
    write_reg(REG_BACKOFF, backoff);
    write_reg(REG_FAST_DEATH, fast);
    write_reg(REG_RESET_LIFE, rlife);
    write_reg(REG_MAX_FAST, maxf);
    write_reg(REG_PRESENT, present);
    write_reg(REG_RESPAWN, respawn);
    write_reg(REG_GFX_ONLY, gfx_only);
    write_reg(REG_GUI_MODE, gui);
  endtask

  // block until every request is taken and every event has come, then let the scan finish
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || s_tvalid || awaited_events.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  // mostly spawn and exit pairs on tracked ids, with starts, ticks and noise
  task automatic queue_random_reqs(int count);
    int          pick;
    int          cat;
    logic [2:0]  s;
    logic [15:0] pid;
    logic        ok;
    logic [31:0] fast;
    logic [31:0] rlife;
    logic [31:0] delta;
    logic [31:0] now;
    fast  = 32'(cfg_shadow.quick_limit);
    rlife = 32'(cfg_shadow.stable_limit);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      s    = 3'($urandom_range(0, 7));
      if (pick < 15) begin
        add_req(REQ_START, 3'($urandom), 16'($urandom), 1'($urandom), gen_now);
      end else if (pick < 45) begin
        cat = $urandom_range(0, 19);
        if (cat == 0) pid = '0;
        else if (cat < 3) pid = gen_pid[$urandom_range(0, 7)];
        else pid = 16'($urandom_range(1, 65535));
        ok = (cat != 19);
        add_req(REQ_SPAWN, s, pid, ok, gen_now);
        if (ok && pid != '0) begin
          gen_pid[s]   = pid;
          gen_start[s] = gen_now;
        end
        gen_now = gen_now + $urandom_range(0, 50);
      end else if (pick < 75) begin
        case ($urandom_range(0, 5))
          0: delta = $urandom_range(0, 3);
          1: delta = $urandom_range(0, fast);
          2: delta = $urandom_range(fast, rlife);
          3: delta = rlife + $urandom_range(1, 5000);
          4: delta = $urandom;
          default: begin
            // straddle one of the two lifetime thresholds
            delta = ($urandom_range(0, 1) != 0) ? fast : rlife;
            delta = delta + $urandom_range(0, 2) - 1;
          end
        endcase
        pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : gen_pid[s];
        now = gen_start[s] + delta;
        add_req(REQ_EXIT, 3'($urandom), pid, 1'($urandom), now);
        gen_now = now;
      end else begin
        if ($urandom_range(0, 15) == 0) now = $urandom;
        else now = gen_now + $urandom_range(0, 32'(cfg_shadow.restart_delay) * 2 + 4);
        add_req(REQ_TICK, 3'($urandom), 16'($urandom), 1'($urandom), now);
        gen_now = now;
      end
    end
  endtask

  // run length guard
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    cfg_shadow = {BACKOFF_RST, FAST_RST, RESET_LIFE_RST, MAX_FAST_RST, 8'd0, 8'd0, 8'd0, 1'b0};
    for (int i = 0; i < 8; i++) begin
      slot_deadline[i] = '0;
      slot_owner[i]    = '0;
      slot_started[i]  = '0;
      slot_quick[i]    = '0;
      gen_pid[i]       = '0;
      gen_start[i]     = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: nothing present, so no events at all
    add_req(REQ_START, 3'd0, 16'd0, 1'b0, 32'd0);
    add_req(REQ_SPAWN, 3'd1, 16'h0055, 1'b1, 32'd0);
    add_req(REQ_TICK, 3'd7, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    add_req(REQ_EXIT, 3'd1, 16'h0055, 1'b0, 32'd10);
    wait_drained();

    // directed: text mode skip, absent slot, shared ids, wrap, thresholds, deadline edges
    set_config(10, 100, 1000, 2, 8'hBF, 8'h7F, 8'h03, 0);
    add_req(REQ_START, 3'd5, 16'd0, 1'b0, 32'd0);
    add_req(REQ_SPAWN, 3'd2, 16'h1234, 1'b1, 32'd1000);
    add_req(REQ_SPAWN, 3'd3, 16'h0000, 1'b1, 32'd1000);
    add_req(REQ_SPAWN, 3'd4, 16'hFFFF, 1'b0, 32'd1000);
    add_req(REQ_SPAWN, 3'd5, 16'h1234, 1'b1, 32'd1000);
    add_req(REQ_SPAWN, 3'd7, 16'hFFFF, 1'b1, 32'hFFFF_FFF0);
    add_req(REQ_SPAWN, 3'd6, 16'h0007, 1'b1, 32'd1000);
    add_req(REQ_EXIT, 3'd0, 16'h1234, 1'b1, 32'd1050);
    add_req(REQ_TICK, 3'd0, 16'd0, 1'b0, 32'd1059);
    add_req(REQ_TICK, 3'd0, 16'd0, 1'b0, 32'd1060);
    add_req(REQ_EXIT, 3'd7, 16'hFFFF, 1'b0, 32'h0000_0010);
    add_req(REQ_EXIT, 3'd6, 16'h0007, 1'b0, 32'd2000);
    add_req(REQ_SPAWN, 3'd2, 16'h1234, 1'b1, 32'd2000);
    add_req(REQ_EXIT, 3'd2, 16'h1234, 1'b0, 32'd2000);
    add_req(REQ_SPAWN, 3'd2, 16'h2222, 1'b1, 32'd3000);
    add_req(REQ_EXIT, 3'd2, 16'h2222, 1'b0, 32'd8000);
    add_req(REQ_START, 3'd3, 16'hAAAA, 1'b1, 32'd8000);
    add_req(REQ_SPAWN, 3'd3, 16'h00AA, 1'b1, 32'd0);
    add_req(REQ_EXIT, 3'd3, 16'h00AA, 1'b1, 32'd500);
    add_req(REQ_TICK, 3'd0, 16'd0, 1'b0, 32'h8000_01FE);
    add_req(REQ_TICK, 3'd0, 16'd0, 1'b0, 32'd509);
    add_req(REQ_TICK, 3'd0, 16'd0, 1'b0, 32'h8000_01FD);
    add_req(REQ_EXIT, 3'd4, 16'h4321, 1'b0, 32'd0);
    wait_drained();

    // graphical mode; receiver holds off while a burst of starts fills the block
    set_config(50, 150, 2000, 3, 8'hFF, 8'hF4, 8'h30, 1);
    hold_trigger = 1'b1;
    repeat (6) add_req(REQ_START, 3'($urandom), 16'($urandom), 1'($urandom), gen_now);
    queue_random_reqs(70);
    wait_drained();

    // repeated fast deaths on one slot until it gives up
    set_config(20, 16'hFFFF, 20'hFFFFF, 8'd30, 8'h01, 8'h01, 8'h00, 0);
    repeat (40) begin
      gen_pid[0] = 16'($urandom_range(1, 65535));
      add_req(REQ_SPAWN, 3'd0, gen_pid[0], 1'b1, gen_now);
      add_req(REQ_EXIT, 3'($urandom), gen_pid[0], 1'($urandom),
              gen_now + $urandom_range(0, 50));
      gen_now = gen_now + 100;
    end
    wait_drained();

    // upper extremes, written with spare high bits that the block drops
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF01,
               32'hFFFF_FF7E, 32'h0000_0003, 32'h0000_005A, 32'hFFFF_FFFF);
    queue_random_reqs(50);
    wait_drained();

    // lower extremes: zero backoff and thresholds, respawnable slots give up at once
    set_config(0, 0, 0, 0, 8'hFF, 8'h0C, 8'hFF, 0);
    queue_random_reqs(40);
    wait_drained();

    // closing stretch with no idling on either side
    idle_on = 1'b0;
    set_config($urandom_range(0, 400), $urandom_range(0, 300), $urandom_range(0, 8000),
               $urandom_range(1, 6), $urandom_range(0, 255), 8'hF0 | 8'($urandom),
               $urandom_range(0, 255), $urandom_range(0, 1));
    queue_random_reqs(55);
    wait_drained();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- service_restart_supervisor_unit.f -----
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_cfg.sv
rtl/srs_resq.sv
rtl/service_restart_supervisor_unit.sv
sim/service_restart_supervisor_unit_tb.sv
